// ----- rtl/cpaf_pkg.sv -----
package cpaf_pkg;

	localparam int NUM_PAGES_DEF   = 32;
	localparam int ID_WIDTH_DEF    = 8;
	localparam int KB_PER_PAGE_DEF = 3;

	localparam int SIZE_W = 7;

	localparam logic ACTION_ALLOC = 1'b0;
	localparam logic ACTION_FREE  = 1'b1;

	localparam logic FIT_WORST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FIT    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

	typedef struct packed {
		logic [5:0] free_pages;
		logic [4:0] fragment_count;
		logic [5:0] pages_used;
		logic [4:0] start_page;
		logic [1:0] status;
	} result_t;

endpackage

// ----- rtl/cpaf_mem.sv -----
module cpaf_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// An entry never written since reset reads as a free page.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvld_q <= valid_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/cpaf_ctrl.sv -----
module cpaf_ctrl #(
	parameter int NUM_PAGES   = cpaf_pkg::NUM_PAGES_DEF,
	parameter int ID_WIDTH    = cpaf_pkg::ID_WIDTH_DEF,
	parameter int KB_PER_PAGE = cpaf_pkg::KB_PER_PAGE_DEF,
	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_action,
	input  logic [ID_WIDTH-1:0]           in_id,
	input  logic [cpaf_pkg::SIZE_W-1:0]   in_size,
	input  logic                          fit_mode,
	input  logic                          out_free,
	output logic                          res_valid,
	output cpaf_pkg::result_t             res,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [ID_WIDTH-1:0]           mem_rdata,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [ID_WIDTH-1:0]           mem_wdata
);

	import cpaf_pkg::*;

	localparam int CNT_W  = $clog2(NUM_PAGES + 1);
	localparam int MAX_KB = NUM_PAGES * KB_PER_PAGE;
	localparam int SHIFT  = 16;
	localparam int RECIP  = ((1 << SHIFT) + KB_PER_PAGE - 1) / KB_PER_PAGE;
	localparam int SUM_W  = SIZE_W + 1;
	localparam int PROD_W = SUM_W + SHIFT + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic                iss_q;
	logic                chk_vld_s1;
	logic [AW-1:0]       chk_idx_s1;
	logic [AW-1:0]       rd_idx_q;

	logic                action_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CNT_W-1:0]    pages_q;
	logic                bad_size_q;

	logic [CNT_W-1:0]    run_len_q;
	logic [AW-1:0]       run_start_q;
	logic [CNT_W-1:0]    runs_q;
	logic [CNT_W-1:0]    total_q;
	logic                prev_free_q;
	logic                fit_found_q;
	logic [CNT_W-1:0]    best_len_q;
	logic [AW-1:0]       best_start_q;
	logic                fr_found_q;
	logic                fr_open_q;
	logic [CNT_W-1:0]    fr_len_q;
	logic [AW-1:0]       fr_start_q;
	logic                fr_prev_q;
	logic                fr_next_q;

	logic [AW-1:0]       wr_addr_q;
	logic [CNT_W-1:0]    wr_left_q;
	logic [ID_WIDTH-1:0] wr_data_q;
	result_t             res_q;

	logic [SUM_W-1:0]    size_sum;
	logic [PROD_W-1:0]   size_prod;
	logic                is_free;
	logic                match;
	logic                last;
	logic [CNT_W-1:0]    cand_len;
	logic [AW-1:0]       cand_start;
	logic                fits;
	logic                better;
	logic                take;

	logic [1:0]          ev_status;
	logic [AW-1:0]       ev_start;
	logic [CNT_W-1:0]    ev_used;
	logic [CNT_W-1:0]    ev_runs;
	logic [CNT_W-1:0]    ev_total;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE) && out_free;
	assign res       = res_q;
	assign mem_raddr = rd_idx_q;
	assign mem_we    = (state_q == S_WRITE);
	assign mem_waddr = wr_addr_q;
	assign mem_wdata = wr_data_q;

	assign size_sum  = SUM_W'(size_q) + SUM_W'(KB_PER_PAGE - 1);
	assign size_prod = PROD_W'(size_sum) * PROD_W'(RECIP);

	assign is_free    = (mem_rdata == '0);
	assign match      = (id_q != '0) && (mem_rdata == id_q);
	assign last       = (chk_idx_s1 == AW'(NUM_PAGES - 1));
	assign cand_len   = is_free ? run_len_q + CNT_W'(1) : run_len_q;
	assign cand_start = (is_free && run_len_q == '0) ? chk_idx_s1 : run_start_q;
	assign fits       = (cand_len >= pages_q) && (cand_len != '0);
	assign better     = (fit_mode == FIT_BEST) ? (cand_len < best_len_q)
						: (cand_len > best_len_q);
	assign take       = (!is_free || last) && fits && (!fit_found_q || better);

	always_comb begin
		ev_status = ST_OK;
		ev_start  = '0;
		ev_used   = '0;
		ev_runs   = runs_q;
		ev_total  = total_q;
		if (action_q == ACTION_ALLOC) begin
			if (bad_size_q) begin
				ev_status = ST_BAD_SIZE;
			end else if (id_q == '0) begin
				ev_status = ST_NOT_FOUND;
			end else if (!fit_found_q) begin
				ev_status = ST_NO_FIT;
			end else begin
				ev_start = best_start_q;
				ev_used  = pages_q;
				ev_runs  = runs_q - CNT_W'(best_len_q == pages_q);
				ev_total = total_q - pages_q;
			end
		end else begin
			if (!fr_found_q) begin
				ev_status = ST_NOT_FOUND;
			end else begin
				ev_start = fr_start_q;
				ev_used  = fr_len_q;
				ev_runs  = runs_q + CNT_W'(1) - CNT_W'(fr_prev_q) - CNT_W'(fr_next_q);
				ev_total = total_q + fr_len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iss_q      <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == S_SCAN) && iss_q;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					iss_q   <= 1'b1;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (iss_q && rd_idx_q == AW'(NUM_PAGES - 1)) begin
						iss_q <= 1'b0;
					end
					if (chk_vld_s1 && last) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= (ev_status == ST_OK) ? S_WRITE : S_DONE;
				end
				S_WRITE: begin
					if (wr_left_q == CNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		case (state_q)
			S_IDLE: begin
				action_q <= in_action;
				id_q     <= in_id;
				size_q   <= in_size;
			end
			S_PREP: begin
				pages_q     <= CNT_W'(size_prod[SHIFT +: SUM_W]);
				bad_size_q  <= (size_q == '0) || (int'(size_q) > MAX_KB);
				rd_idx_q    <= '0;
				run_len_q   <= '0;
				run_start_q <= '0;
				runs_q      <= '0;
				total_q     <= '0;
				prev_free_q <= 1'b0;
				fit_found_q <= 1'b0;
				best_len_q  <= '0;
				best_start_q <= '0;
				fr_found_q  <= 1'b0;
				fr_open_q   <= 1'b0;
				fr_len_q    <= '0;
				fr_start_q  <= '0;
				fr_prev_q   <= 1'b0;
				fr_next_q   <= 1'b0;
			end
			S_SCAN: begin
				if (iss_q) begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
				if (chk_vld_s1) begin
					prev_free_q <= is_free;
					if (is_free) begin
						total_q <= total_q + CNT_W'(1);
						if (!prev_free_q) begin
							runs_q <= runs_q + CNT_W'(1);
						end
					end
					run_len_q   <= is_free ? cand_len : '0;
					run_start_q <= cand_start;
					if (take) begin
						fit_found_q  <= 1'b1;
						best_len_q   <= cand_len;
						best_start_q <= cand_start;
					end
					if (!fr_found_q && match) begin
						fr_found_q <= 1'b1;
						fr_open_q  <= 1'b1;
						fr_len_q   <= CNT_W'(1);
						fr_start_q <= chk_idx_s1;
						fr_prev_q  <= prev_free_q;
					end else if (fr_open_q && match) begin
						fr_len_q <= fr_len_q + CNT_W'(1);
					end else if (fr_open_q) begin
						fr_open_q <= 1'b0;
						fr_next_q <= is_free;
					end
				end
			end
			S_EVAL: begin
				wr_addr_q <= ev_start;
				wr_left_q <= ev_used;
				wr_data_q <= (action_q == ACTION_ALLOC) ? id_q : '0;
				res_q.status         <= ev_status;
				res_q.start_page     <= 5'(ev_start);
				res_q.pages_used     <= 6'(ev_used);
				res_q.fragment_count <= 5'(ev_runs);
				res_q.free_pages     <= 6'(ev_total);
			end
			S_WRITE: begin
				wr_addr_q <= wr_addr_q + AW'(1);
				wr_left_q <= wr_left_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/contiguous_page_allocator_fit.sv -----
// Each item scans every page of the page map; a successful allocate or free then
// writes each page that it takes or releases before the result is given.
// One item is in work at a time; the next is taken while a result waits, in the cycle
// after the result leaves the control.
// Reset marks every page free and selects worst fit.
module contiguous_page_allocator_fit #(
	parameter int NUM_PAGES   = cpaf_pkg::NUM_PAGES_DEF,
	parameter int ID_WIDTH    = cpaf_pkg::ID_WIDTH_DEF,
	parameter int KB_PER_PAGE = cpaf_pkg::KB_PER_PAGE_DEF,
	localparam int IN_W = ((ID_WIDTH + cpaf_pkg::SIZE_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// program_id, size_kb
	input  logic [IN_W-1:0]               s_tdata,
	// action
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, start_page, pages_used, fragment_count, free_pages
	output logic [$bits(cpaf_pkg::result_t)-1:0] m_tdata
);

	import cpaf_pkg::*;

	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

	logic                fit_mode_q;
	logic                m_tvalid_q;
	result_t             m_tdata_q;
	logic                out_free;
	logic                res_valid;
	result_t             res;
	logic [AW-1:0]       mem_raddr;
	logic [ID_WIDTH-1:0] mem_rdata;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [ID_WIDTH-1:0] mem_wdata;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_WORST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				fit_mode_q <= cfg_wdata;
			end
			if (res_valid) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= res;
		end
	end

	cpaf_ctrl #(
		.NUM_PAGES  (NUM_PAGES),
		.ID_WIDTH   (ID_WIDTH),
		.KB_PER_PAGE(KB_PER_PAGE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_action(s_tuser),
		.in_id    (s_tdata[ID_WIDTH-1:0]),
		.in_size  (s_tdata[ID_WIDTH +: SIZE_W]),
		.fit_mode (fit_mode_q),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	cpaf_mem #(
		.DEPTH(NUM_PAGES),
		.WIDTH(ID_WIDTH)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- test/page_alloc_checker.sv -----
`timescale 1ns / 1ps

module page_alloc_checker #(
	localparam int PAGES   = cpaf_pkg::NUM_PAGES_DEF,
	localparam int KB_PAGE = cpaf_pkg::KB_PER_PAGE_DEF,
	localparam int IN_W    = ((cpaf_pkg::ID_WIDTH_DEF + cpaf_pkg::SIZE_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic                  cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// program_id, size_kb
	input  logic [IN_W-1:0]       s_tdata,
	// action
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// status, start_page, pages_used, fragment_count, free_pages
	input  logic [$bits(cpaf_pkg::result_t)-1:0] m_tdata,
	output int                    pending,
	output int                    failures
);

	import cpaf_pkg::*;

	logic [ID_WIDTH_DEF-1:0] page_map [PAGES];
	logic                    fit_sel;
	result_t                 awaited_outcomes [$];
	int                      fail_count = 0;
	int                      results_seen = 0;

	assign failures = fail_count;

	task automatic flag_mismatch(input string what);
		fail_count++;
		$display("%s", what);
	endtask

	function automatic result_t apply_request(input logic act,
			input logic [ID_WIDTH_DEF-1:0] id, input logic [SIZE_W-1:0] size_kb);
		result_t r;
		int pages, run_start, run_len, best_start, best_len, runs, total, i;
		bit found, was_free, take;
		r = '0;
		found = 1'b0;
		best_start = 0;
		best_len = 0;
		if (act == ACTION_ALLOC) begin
			if (size_kb == 0 || int'(size_kb) > PAGES * KB_PAGE) begin
				r.status = ST_BAD_SIZE;
			end else if (id == 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				pages = (int'(size_kb) + KB_PAGE - 1) / KB_PAGE;
				run_start = 0;
				run_len = 0;
				for (i = 0; i <= PAGES; i++) begin
					if (i < PAGES && page_map[i] == 0) begin
						if (run_len == 0)
							run_start = i;
						run_len++;
					end else begin
						if (run_len >= pages) begin
							if (!found)
								take = 1'b1;
							else if (fit_sel == FIT_BEST)
								take = run_len < best_len;
							else
								take = run_len > best_len;
							if (take) begin
								found = 1'b1;
								best_len = run_len;
								best_start = run_start;
							end
						end
						run_len = 0;
					end
				end
				if (found) begin
					for (i = 0; i < pages; i++)
						page_map[best_start + i] = id;
					r.start_page = best_start[4:0];
					r.pages_used = pages[5:0];
				end else begin
					r.status = ST_NO_FIT;
				end
			end
		end else begin
			if (id != 0) begin
				for (i = 0; i < PAGES; i++) begin
					if (!found && page_map[i] == id) begin
						found = 1'b1;
						best_start = i;
					end
				end
			end
			if (found) begin
				r.start_page = best_start[4:0];
				i = best_start;
				while (i < PAGES && page_map[i] == id) begin
					page_map[i] = '0;
					r.pages_used++;
					i++;
				end
			end else begin
				r.status = ST_NOT_FOUND;
			end
		end
		runs = 0;
		total = 0;
		was_free = 1'b0;
		for (i = 0; i < PAGES; i++) begin
			if (page_map[i] == 0) begin
				total++;
				if (!was_free)
					runs++;
			end
			was_free = (page_map[i] == 0);
		end
		r.fragment_count = runs[4:0];
		r.free_pages = total[5:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			foreach (page_map[k])
				page_map[k] = '0;
			fit_sel = FIT_WORST;
			awaited_outcomes.delete();
			pending <= 0;
		end else begin
			if (cfg_wen)
				fit_sel = cfg_wdata;
			if (s_tvalid && s_tready)
				awaited_outcomes.push_back(apply_request(s_tuser,
					s_tdata[ID_WIDTH_DEF-1:0], s_tdata[ID_WIDTH_DEF +: SIZE_W]));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (awaited_outcomes.size() == 0) begin
					flag_mismatch($sformatf("Result %0d arrived with nothing awaited: %h",
						results_seen, m_tdata));
				end else begin
					want = awaited_outcomes.pop_front();
					if (got.status !== want.status || got.start_page !== want.start_page ||
							got.pages_used !== want.pages_used ||
							got.fragment_count !== want.fragment_count ||
							got.free_pages !== want.free_pages)
						flag_mismatch($sformatf({"Result %0d wrong: status %0d/%0d start %0d/%0d",
							" pages %0d/%0d runs %0d/%0d free %0d/%0d (got/expected)"},
							results_seen, got.status, want.status, got.start_page,
							want.start_page, got.pages_used, want.pages_used,
							got.fragment_count, want.fragment_count, got.free_pages,
							want.free_pages));
				end
				results_seen++;
			end
			pending <= awaited_outcomes.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import cpaf_pkg::*;

	localparam int IN_W = ((ID_WIDTH_DEF + SIZE_W + 7) / 8) * 8;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wen;
	logic                        cfg_wdata;
	logic                        s_tvalid;
	logic                        s_tready;
	// program_id, size_kb
	logic [IN_W-1:0]             s_tdata;
	// action
	logic                        s_tuser;
	logic                        m_tvalid;
	logic                        m_tready;
	// status, start_page, pages_used, fragment_count, free_pages
	logic [$bits(result_t)-1:0]  m_tdata;
	int                          pending;
	int                          failures;
	int                          idle_pct = 28;
	bit                          hold_req = 1'b0;

	contiguous_page_allocator_fit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	page_alloc_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.pending   (pending),
		.failures  (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("contiguous_page_allocator_fit verification failed");
		$finish;
	end

	// The receiver stalls at random; once asked, it holds off long enough for the
	// block to fill up and stop taking items.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic offer(input logic act, input logic [ID_WIDTH_DEF-1:0] id,
			input logic [SIZE_W-1:0] kb);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= IN_W'({kb, id});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_fit(input logic mode);
		cfg_wen <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic churn(input int n, input int first_id, input int span);
		int roll;
		logic [ID_WIDTH_DEF-1:0] id;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			id = ID_WIDTH_DEF'(first_id + $urandom_range(span - 1));
			if (roll < 5) begin
				case ($urandom_range(3))
					0: offer(ACTION_ALLOC, id, '0);
					1: offer(ACTION_ALLOC, id, SIZE_W'($urandom_range(127, 97)));
					2: offer(1'($urandom_range(1)), '0, SIZE_W'($urandom_range(127)));
					default: offer(1'($urandom_range(1)), ID_WIDTH_DEF'($urandom_range(255)),
						SIZE_W'($urandom_range(127)));
				endcase
			end else if (roll < 58) begin
				if ($urandom_range(4) == 0)
					offer(ACTION_ALLOC, id, SIZE_W'($urandom_range(96, 1)));
				else
					offer(ACTION_ALLOC, id, SIZE_W'($urandom_range(15, 1)));
			end else begin
				offer(ACTION_FREE, id, SIZE_W'($urandom_range(127)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_fit(FIT_WORST);
		offer(ACTION_ALLOC, 8'd1, 7'd0);
		offer(ACTION_ALLOC, 8'd1, 7'd97);
		offer(ACTION_ALLOC, 8'd127, 7'd127);
		offer(ACTION_ALLOC, 8'd0, 7'd3);
		offer(ACTION_FREE, 8'd0, 7'd0);
		offer(ACTION_FREE, 8'd9, 7'd5);
		offer(ACTION_ALLOC, 8'd255, 7'd96);
		offer(ACTION_ALLOC, 8'd1, 7'd1);
		offer(ACTION_FREE, 8'd255, 7'd127);
		offer(ACTION_ALLOC, 8'd1, 7'd1);
		offer(ACTION_ALLOC, 8'd2, 7'd4);
		offer(ACTION_ALLOC, 8'd3, 7'd3);
		offer(ACTION_ALLOC, 8'd1, 7'd6);
		offer(ACTION_FREE, 8'd2, 7'd0);
		offer(ACTION_ALLOC, 8'd4, 7'd2);
		offer(ACTION_FREE, 8'd1, 7'd0);
		offer(ACTION_FREE, 8'd1, 7'd0);
		offer(ACTION_ALLOC, 8'd5, 7'd95);
		offer(ACTION_ALLOC, 8'd6, 7'd7);
		offer(ACTION_ALLOC, 8'd128, 7'd50);
		offer(ACTION_ALLOC, 8'd7, 7'd70);
		offer(ACTION_ALLOC, 8'd7, 7'd3);
		offer(ACTION_FREE, 8'd7, 7'd0);
		settle();

		set_fit(FIT_BEST);
		churn(135, 1, 10);
		settle();

		idle_pct = 0;
		set_fit(FIT_WORST);
		churn(105, 240, 12);
		settle();

		idle_pct = 28;
		set_fit(FIT_BEST);
		hold_req = 1'b1;
		churn(135, 1, 8);
		settle();

		set_fit(FIT_WORST);
		churn(135, 100, 16);
		settle();

		repeat (80) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("contiguous_page_allocator_fit verification clean");
		else
			$display("contiguous_page_allocator_fit verification failed");
		$finish;
	end

endmodule
